[rtl/assert_macros.svh]
// assertion macros used by the checker file
// depends on nothing; callers supply clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define PHHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent holds in the cycle after the trigger
`define PHHT_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[rtl/phht_pkg.sv]
// shared types, constants and helpers for the port handle hash table
// depends on nothing
`default_nettype none

package phht_pkg;

    // table geometry; BUCKETS is a power of two so the bucket is the low hash bits
    localparam int BUCKETS = 256;
    localparam int WAYS    = 4;

    localparam int PORT_W   = 16;
    localparam int HANDLE_W = 32;
    localparam int HASH_W   = 32;
    localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int FILL_W   = $clog2(WAYS + 1);
    localparam int ADDR_W   = ((BUCKETS * WAYS) > 1) ? $clog2(BUCKETS * WAYS) : 1;

    localparam logic [HASH_W-1:0] HASH_MUL   = 32'h045d_9f3b;
    localparam int                HASH_SHIFT = 16;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;

    // status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef logic [BKT_W-1:0]  bucket_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [PORT_W-1:0]   port;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // hash unit control
    typedef struct packed {
        logic load;
        logic step;
    } hash_ctrl_t;

    // entry memory write request
    typedef struct packed {
        logic   we;
        addr_t  addr;
        entry_t data;
    } entry_wr_t;

    // fill table write request
    typedef struct packed {
        logic    we;
        bucket_t addr;
        fill_t   data;
    } fill_wr_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_FILL_RD,
        S_FILL_CHK,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    // flat slot address of a way inside a bucket
    function automatic addr_t entry_addr(input bucket_t b, input fill_t w);
        addr_t base;
        base = addr_t'(b) * addr_t'(WAYS);
        return addr_t'(base + addr_t'(w));
    endfunction

endpackage

`default_nettype wire

[rtl/phht_hash_unit.sv]
// iterative port hash: one xor-shift-multiply round per step on a shared multiplier
// depends on phht_pkg
`default_nettype none

module phht_hash_unit
(
    input  wire logic                              clk,
    input  wire phht_pkg::hash_ctrl_t              ctrl,
    input  wire logic [phht_pkg::PORT_W-1:0]       key,
    output      phht_pkg::bucket_t                 bucket
);

    logic [phht_pkg::HASH_W-1:0] x_reg;
    logic [phht_pkg::HASH_W-1:0] x_next;
    logic [phht_pkg::HASH_W-1:0] mix;

    // xor-fold of the upper half into the lower half
    assign mix = x_reg ^ (x_reg >> phht_pkg::HASH_SHIFT);

    // final fold, reduced to the bucket index
    assign bucket = mix[phht_pkg::BKT_W-1:0];

    // load the key or run one multiply round
    always_comb
    begin
        x_next = x_reg;
        if (ctrl.load)
        begin
            x_next = phht_pkg::HASH_W'(key);
        end
        else if (ctrl.step)
        begin
            x_next = phht_pkg::HASH_W'(mix * phht_pkg::HASH_MUL);
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

endmodule

`default_nettype wire

[rtl/phht_entry_ram.sv]
// entry slot memory: one write port, one registered read port
// depends on phht_pkg
`default_nettype none

module phht_entry_ram
(
    input  wire logic                clk,
    input  wire phht_pkg::entry_wr_t wr,
    input  wire phht_pkg::addr_t     raddr,
    output      phht_pkg::entry_t    rdata
);

    phht_pkg::entry_t mem [phht_pkg::BUCKETS * phht_pkg::WAYS];
    phht_pkg::entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/phht_fill_table.sv]
// per-bucket fill counts: memory plus reset-cleared valid bits
// depends on phht_pkg
`default_nettype none

module phht_fill_table
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire phht_pkg::fill_wr_t wr,
    input  wire phht_pkg::bucket_t  raddr,
    output      phht_pkg::fill_t    rdata
);

    phht_pkg::fill_t                mem [phht_pkg::BUCKETS];
    logic [phht_pkg::BUCKETS-1:0]   valid_reg;
    phht_pkg::fill_t                rdata_reg;

    // count storage
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // valid bits: a bucket never written reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.we)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/port_handle_hash_table.sv]
// top level: command sequencer of the port handle hash table
// depends on phht_pkg, phht_hash_unit, phht_entry_ram, phht_fill_table
`default_nettype none

// Maps a 16-bit port to a 32-bit handle in 256 buckets of 4 ways. An item is
// taken when start is high and busy is low; its single result appears for one
// cycle with done high, and the receiver cannot stall it. An accepted item
// passes two hash states, a fill read and a fill check; an insert or an unused
// command then ends, a lookup or pop scans the bucket's ways in order, and a
// pop that hits moves each later entry up one way; busy drops the cycle after
// done. The two hash rounds share one multiplier, and every way scanned or
// moved passes a read state and a compare or write state on the single read
// port of the entry memory. No clearing pass is needed after reset.
module port_handle_hash_table
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [15:0] port,
    input  wire logic [31:0] handle,
    output      logic        done,
    output      logic        found,
    output      logic [31:0] handle_out,
    output      logic        status
);

    phht_pkg::state_t   state_reg, state_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [15:0]        port_reg, port_next;
    logic [31:0]        handle_reg, handle_next;
    phht_pkg::bucket_t  bucket_reg, bucket_next;
    phht_pkg::fill_t    fill_reg, fill_next;
    phht_pkg::fill_t    way_reg, way_next;
    logic               found_reg, found_next;
    logic [31:0]        hout_reg, hout_next;
    logic               status_reg, status_next;

    phht_pkg::hash_ctrl_t hash_ctrl;
    phht_pkg::bucket_t    hash_bucket;
    phht_pkg::entry_wr_t  ent_wr;
    phht_pkg::addr_t      ent_raddr;
    phht_pkg::entry_t     ent_rdata;
    phht_pkg::fill_wr_t   fill_wr;
    phht_pkg::fill_t      fill_rdata;
    phht_pkg::fill_t      way_inc;

    phht_hash_unit u_hash
    (
        .clk    (clk),
        .ctrl   (hash_ctrl),
        .key    (port),
        .bucket (hash_bucket)
    );

    phht_entry_ram u_entries
    (
        .clk   (clk),
        .wr    (ent_wr),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    phht_fill_table u_fill
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fill_wr),
        .raddr (hash_bucket),
        .rdata (fill_rdata)
    );

    assign way_inc = phht_pkg::fill_t'(way_reg + 1'b1);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= phht_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item payload and working registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        port_reg   <= port_next;
        handle_reg <= handle_next;
        bucket_reg <= bucket_next;
        fill_reg   <= fill_next;
        way_reg    <= way_next;
        found_reg  <= found_next;
        hout_reg   <= hout_next;
        status_reg <= status_next;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        port_next   = port_reg;
        handle_next = handle_reg;
        bucket_next = bucket_reg;
        fill_next   = fill_reg;
        way_next    = way_reg;
        found_next  = found_reg;
        hout_next   = hout_reg;
        status_next = status_reg;

        hash_ctrl      = '0;
        ent_wr.we      = 1'b0;
        ent_wr.addr    = phht_pkg::entry_addr(bucket_reg, way_reg);
        ent_wr.data    = ent_rdata;
        ent_raddr      = phht_pkg::entry_addr(bucket_reg, way_reg);
        fill_wr.we     = 1'b0;
        fill_wr.addr   = bucket_reg;
        fill_wr.data   = fill_reg;

        case (state_reg)
            phht_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next       = cmd;
                    port_next      = port;
                    handle_next    = handle;
                    found_next     = 1'b0;
                    hout_next      = '0;
                    status_next    = phht_pkg::ST_OK;
                    hash_ctrl.load = 1'b1;
                    state_next     = phht_pkg::S_HASH1;
                end
            end

            phht_pkg::S_HASH1:
            begin
                hash_ctrl.step = 1'b1;
                state_next     = phht_pkg::S_HASH2;
            end

            phht_pkg::S_HASH2:
            begin
                hash_ctrl.step = 1'b1;
                state_next     = phht_pkg::S_FILL_RD;
            end

            // fill table reads the hash bucket this cycle
            phht_pkg::S_FILL_RD:
            begin
                bucket_next = hash_bucket;
                state_next  = phht_pkg::S_FILL_CHK;
            end

            phht_pkg::S_FILL_CHK:
            begin
                fill_next  = fill_rdata;
                way_next   = '0;
                state_next = phht_pkg::S_DONE;
                case (cmd_reg)
                    phht_pkg::CMD_INSERT:
                    begin
                        if (fill_rdata >= phht_pkg::fill_t'(phht_pkg::WAYS))
                        begin
                            status_next = phht_pkg::ST_FULL;
                        end
                        else
                        begin
                            ent_wr.we    = 1'b1;
                            ent_wr.addr  = phht_pkg::entry_addr(bucket_reg, fill_rdata);
                            ent_wr.data  = '{port: port_reg, handle: handle_reg};
                            fill_wr.we   = 1'b1;
                            fill_wr.data = phht_pkg::fill_t'(fill_rdata + 1'b1);
                        end
                    end
                    phht_pkg::CMD_LOOKUP, phht_pkg::CMD_POP:
                    begin
                        state_next = phht_pkg::S_SCAN_RD;
                    end
                    default:
                    begin
                        state_next = phht_pkg::S_DONE;
                    end
                endcase
            end

            // read the next way, or stop on a miss
            phht_pkg::S_SCAN_RD:
            begin
                if (way_reg >= fill_reg)
                begin
                    state_next = phht_pkg::S_DONE;
                end
                else
                begin
                    state_next = phht_pkg::S_SCAN_CMP;
                end
            end

            phht_pkg::S_SCAN_CMP:
            begin
                if (ent_rdata.port == port_reg)
                begin
                    found_next = 1'b1;
                    hout_next  = ent_rdata.handle;
                    if (cmd_reg == phht_pkg::CMD_POP)
                    begin
                        state_next = phht_pkg::S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = phht_pkg::S_DONE;
                    end
                end
                else
                begin
                    way_next   = way_inc;
                    state_next = phht_pkg::S_SCAN_RD;
                end
            end

            // move the entry behind up, or shrink the bucket when none is left
            phht_pkg::S_SHIFT_RD:
            begin
                if (way_inc < fill_reg)
                begin
                    ent_raddr  = phht_pkg::entry_addr(bucket_reg, way_inc);
                    state_next = phht_pkg::S_SHIFT_WR;
                end
                else
                begin
                    fill_wr.we   = 1'b1;
                    fill_wr.data = phht_pkg::fill_t'(fill_reg - 1'b1);
                    state_next   = phht_pkg::S_DONE;
                end
            end

            phht_pkg::S_SHIFT_WR:
            begin
                ent_wr.we  = 1'b1;
                ent_wr.data = ent_rdata;
                way_next   = way_inc;
                state_next = phht_pkg::S_SHIFT_RD;
            end

            phht_pkg::S_DONE:
            begin
                state_next = phht_pkg::S_IDLE;
            end

            default:
            begin
                state_next = phht_pkg::S_IDLE;
            end
        endcase
    end

    // result ports
    assign busy       = (state_reg != phht_pkg::S_IDLE);
    assign done       = (state_reg == phht_pkg::S_DONE);
    assign found      = found_reg;
    assign handle_out = hout_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

[rtl/phht_checker.sv]
// port-level checks for the port handle hash table, bound to the top level
// depends on assert_macros.svh and port_handle_hash_table
`default_nettype none
`include "assert_macros.svh"

module phht_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        found,
    input wire logic [31:0] handle_out,
    input wire logic        status
);

    // a result only comes while an item is in work
    `PHHT_ASSERT(a_done_busy, (!done || busy), "done without an item in work")

    // an accepted item keeps the block busy
    `PHHT_ASSERT_NEXT(a_accept_busy, (start && !busy), busy, "busy low after accept")

    // the result strobe is never repeated, and busy drops after it
    `PHHT_ASSERT_NEXT(a_done_single, done, (!done && !busy), "result strobe repeated")

    // a miss carries the null handle
    `PHHT_ASSERT(a_miss_null, (!(done && !found) || (handle_out == 32'd0)), "miss with handle")

    // a rejected insert never reports a hit
    `PHHT_ASSERT(a_full_nohit, (!(done && status) || !found), "full status with hit")

endmodule

bind port_handle_hash_table phht_checker u_phht_checker (.*);

`default_nettype wire

[sim/tb_port_handle_hash_table.sv]
// self-checking testbench for port_handle_hash_table: directed and random item stream
// depends on phht_pkg and port_handle_hash_table; predicts each result with its own table
`timescale 1ns / 1ps

module tb_port_handle_hash_table;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int NUM_RANDOM = 1030;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 40;
    localparam int GROUPS = 6;
    localparam int GROUP_SIZE = 6;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] key;
        logic [31:0] hdl;
        bit          drain;
    } table_item_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] hdl;
        logic        st;
    } table_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  cmd = 2'd0;
    logic [15:0] port = 16'd0;
    logic [31:0] handle = 32'd0;
    logic        busy;
    logic        done;
    logic        found;
    logic [31:0] handle_out;
    logic        status;

    // shadow copy of the table
    logic [15:0] slot_key [phht_pkg::BUCKETS*phht_pkg::WAYS];
    logic [31:0] slot_hdl [phht_pkg::BUCKETS*phht_pkg::WAYS];
    int          fill_cnt [phht_pkg::BUCKETS];

    table_item_t  pending_q [$];
    table_reply_t expected_q [$];
    logic [15:0]  group_port [GROUPS][GROUP_SIZE];

    int errors = 0;
    int taken_cnt = 0;
    int issued_cnt = 0;
    int gap_left = 0;
    int stall_cycles = 0;
    bit progress;
    table_item_t  next_item;
    table_reply_t want;

    port_handle_hash_table u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .port       (port),
        .handle     (handle),
        .done       (done),
        .found      (found),
        .handle_out (handle_out),
        .status     (status)
    );

    // clock and single reset
    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // integer hash of a port, reduced to its bucket
    function automatic int bucket_for(input logic [15:0] key);
        logic [31:0] x;
        x = {16'd0, key};
        x = ((x >> phht_pkg::HASH_SHIFT) ^ x) * phht_pkg::HASH_MUL;
        x = ((x >> phht_pkg::HASH_SHIFT) ^ x) * phht_pkg::HASH_MUL;
        x = (x >> phht_pkg::HASH_SHIFT) ^ x;
        return int'(x % phht_pkg::BUCKETS);
    endfunction

    // apply one item to the shadow table and return its result
    function automatic table_reply_t predict_reply(input logic [1:0] op,
                                                   input logic [15:0] key,
                                                   input logic [31:0] hdl);
        table_reply_t r;
        int b;
        int n;
        int hit_way;
        r = '0;
        b = bucket_for(key);
        n = fill_cnt[b];
        hit_way = -1;
        case (op)
            phht_pkg::CMD_INSERT:
            begin
                if (n >= phht_pkg::WAYS)
                    r.st = phht_pkg::ST_FULL;
                else
                begin
                    slot_key[b*phht_pkg::WAYS + n] = key;
                    slot_hdl[b*phht_pkg::WAYS + n] = hdl;
                    fill_cnt[b] = n + 1;
                end
            end
            phht_pkg::CMD_LOOKUP, phht_pkg::CMD_POP:
            begin
                for (int w = 0; w < n; w++)
                    if (hit_way < 0 && slot_key[b*phht_pkg::WAYS + w] == key)
                        hit_way = w;
                if (hit_way >= 0)
                begin
                    r.hit = 1'b1;
                    r.hdl = slot_hdl[b*phht_pkg::WAYS + hit_way];
                    if (op == phht_pkg::CMD_POP)
                    begin
                        // later entries move up one way
                        for (int k = hit_way; k + 1 < n; k++)
                        begin
                            slot_key[b*phht_pkg::WAYS + k] = slot_key[b*phht_pkg::WAYS + k + 1];
                            slot_hdl[b*phht_pkg::WAYS + k] = slot_hdl[b*phht_pkg::WAYS + k + 1];
                        end
                        fill_cnt[b] = n - 1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        // every third stretch of 80 items runs back to back
        if ((taken_cnt / 80) % 3 == 0 || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_handle();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input logic [1:0] op, input logic [15:0] key,
                             input logic [31:0] hdl, input bit drain);
        table_item_t it;
        it.op = op;
        it.key = key;
        it.hdl = hdl;
        it.drain = drain;
        pending_q.push_back(it);
    endtask

    // driver: presents items at the falling edge, holds until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && taken_cnt != issued_cnt))
        begin
            if (start)
                gap_left = pick_gap();
            else if (gap_left > 0)
                gap_left = gap_left - 1;
            if (gap_left == 0 && pending_q.size() > 0
                && !(pending_q[0].drain && expected_q.size() > 0))
            begin
                next_item = pending_q.pop_front();
                cmd <= next_item.op;
                port <= next_item.key;
                handle <= next_item.hdl;
                start <= 1'b1;
                issued_cnt = issued_cnt + 1;
            end
            else
            begin
                // junk on the data inputs while idle
                cmd <= 2'($urandom);
                port <= 16'($urandom);
                handle <= $urandom;
                start <= 1'b0;
            end
        end
    end

    // monitor: checks results and records accepted items at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            progress = 1'b0;
            if (done)
            begin
                progress = 1'b1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with none expected: found %0b handle %h status %0b",
                             $time, found, handle_out, status);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (found !== want.hit)
                    begin
                        $display("%0t: found expected %0b actual %0b", $time, want.hit, found);
                        errors++;
                    end
                    if (handle_out !== want.hdl)
                    begin
                        $display("%0t: handle_out expected %h actual %h",
                                 $time, want.hdl, handle_out);
                        errors++;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0b actual %0b", $time, want.st, status);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                progress = 1'b1;
                expected_q.push_back(predict_reply(cmd, port, handle));
                taken_cnt++;
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("port_handle_hash_table: mismatch");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        int target;
        int cnt;
        int ins_w;
        int r;
        logic [15:0] p;
        logic [15:0] key;
        logic [1:0] op;
        logic [15:0] g [GROUP_SIZE];

        for (int i = 0; i < phht_pkg::BUCKETS*phht_pkg::WAYS; i++)
        begin
            slot_key[i] = '0;
            slot_hdl[i] = '0;
        end
        for (int i = 0; i < phht_pkg::BUCKETS; i++)
            fill_cnt[i] = 0;

        // groups of ports that share one bucket
        for (int gi = 0; gi < GROUPS; gi++)
        begin
            p = 16'($urandom);
            target = bucket_for(p);
            cnt = 0;
            while (cnt < GROUP_SIZE)
            begin
                if (bucket_for(p) == target)
                begin
                    group_port[gi][cnt] = p;
                    cnt++;
                end
                p = p + 16'd1;
            end
        end
        for (int i = 0; i < GROUP_SIZE; i++)
            g[i] = group_port[0][i];

        // misses in an empty bucket
        push_item(phht_pkg::CMD_LOOKUP, g[0], 32'h1111_1111, 1'b0);
        push_item(phht_pkg::CMD_POP, g[0], 32'h2222_2222, 1'b0);
        // fill one bucket, with a zero handle and a duplicate port
        push_item(phht_pkg::CMD_INSERT, g[0], 32'd0, 1'b0);
        push_item(phht_pkg::CMD_INSERT, g[1], 32'hffff_ffff, 1'b0);
        push_item(phht_pkg::CMD_INSERT, g[0], 32'h1234_5678, 1'b0);
        push_item(phht_pkg::CMD_INSERT, g[2], $urandom, 1'b0);
        // full bucket rejects
        push_item(phht_pkg::CMD_INSERT, g[3], $urandom, 1'b0);
        // hit on the oldest copy, hit in the last way, miss in a full bucket
        push_item(phht_pkg::CMD_LOOKUP, g[0], $urandom, 1'b0);
        push_item(phht_pkg::CMD_LOOKUP, g[2], $urandom, 1'b0);
        push_item(phht_pkg::CMD_LOOKUP, g[3], $urandom, 1'b0);
        // pop from the middle, then from the head of the chain
        push_item(phht_pkg::CMD_POP, g[1], $urandom, 1'b0);
        push_item(phht_pkg::CMD_POP, g[0], $urandom, 1'b0);
        push_item(phht_pkg::CMD_LOOKUP, g[0], $urandom, 1'b0);
        push_item(phht_pkg::CMD_LOOKUP, g[2], $urandom, 1'b0);
        // unused command is ignored
        push_item(CMD_UNUSED, 16'hffff, 32'hffff_ffff, 1'b0);
        // key extremes
        push_item(phht_pkg::CMD_INSERT, 16'h0000, 32'hffff_ffff, 1'b0);
        push_item(phht_pkg::CMD_INSERT, 16'hffff, 32'd0, 1'b0);
        push_item(phht_pkg::CMD_LOOKUP, 16'h0000, 32'd0, 1'b0);
        push_item(phht_pkg::CMD_POP, 16'hffff, 32'hffff_ffff, 1'b0);
        push_item(phht_pkg::CMD_LOOKUP, 16'hffff, 32'd0, 1'b0);
        // empty the bucket again
        push_item(phht_pkg::CMD_POP, g[0], $urandom, 1'b0);
        push_item(phht_pkg::CMD_POP, g[2], $urandom, 1'b0);
        push_item(phht_pkg::CMD_LOOKUP, g[2], $urandom, 1'b1);

        // random part: mostly colliding ports, insert share varies by stretch
        ins_w = 40;
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 100 == 0)
                ins_w = $urandom_range(25, 55);
            r = $urandom_range(0, 99);
            if (r < ins_w)
                op = phht_pkg::CMD_INSERT;
            else if (r < 95)
                op = $urandom_range(0, 1) ? phht_pkg::CMD_LOOKUP : phht_pkg::CMD_POP;
            else
                op = CMD_UNUSED;
            if ($urandom_range(0, 99) < 80)
                key = group_port[$urandom_range(0, GROUPS-1)][$urandom_range(0, GROUP_SIZE-1)];
            else
                key = 16'($urandom);
            push_item(op, key, pick_handle(), (i % 150 == 75) || ($urandom_range(0, 99) == 0));
        end

        // wait for all items and results, then a quiet tail
        while (pending_q.size() != 0 || start || expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("port_handle_hash_table: match");
        else
            $display("port_handle_hash_table: mismatch");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/phht_pkg.sv
rtl/phht_hash_unit.sv
rtl/phht_entry_ram.sv
rtl/phht_fill_table.sv
rtl/port_handle_hash_table.sv
rtl/phht_checker.sv
sim/tb_port_handle_hash_table.sv
